// ===== src/hps_pkg.sv =====
// Shared types, constants and pattern ROM for the haptic pattern sequencer
package hps_pkg;

  localparam int STEPS_PER_PATTERN = 32;
  localparam int TICK_MS           = 50;
  localparam int FADE_UNIT_MS      = 2 * TICK_MS;

  localparam int DUTY_W   = 7;
  localparam int FDIV_W   = 8;
  localparam int STEP_W   = 5;
  localparam int REP_W    = 4;
  localparam int PAT_W    = 3;
  localparam int OP_W     = 2;
  localparam int MS_W     = 16;
  localparam int COUNT_W  = 32;
  localparam int DIV_CNT_W = $clog2(DUTY_W + 1);

  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RESET = DUTY_W'(100);
  localparam logic [PAT_W-1:0]  BREATH_ID        = PAT_W'(4);

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 2'd0,
    OP_START      = 2'd1,
    OP_START_IDLE = 2'd2
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PREP,
    S_LSTART,
    S_LWAIT,
    S_RSTART,
    S_RWAIT,
    S_ADVANCE,
    S_PUBLISH
  } state_t;

  typedef struct packed {
    logic take;
    logic decode;
    logic prep;
    logic div_start;
    logic side_right;
    logic apply;
    logic advance;
    logic publish;
  } hps_ctl_t;

  typedef struct packed {
    logic item_valid;
    logic tick_live;
    logic fade_any;
    logic div_done;
    logic out_free;
  } hps_stat_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left;
    logic [DUTY_W-1:0] right;
    logic [MS_W-1:0]   dur;
    logic              fin;
    logic              fout;
    logic [FDIV_W-1:0] fdiv;
  } step_t;

  function automatic step_t mk_step(int l, int r, int d, bit fi, bit fo, int fd);
    step_t s;
    s.left  = DUTY_W'(l);
    s.right = DUTY_W'(r);
    s.dur   = MS_W'(d);
    s.fin   = fi;
    s.fout  = fo;
    s.fdiv  = FDIV_W'(fd);
    return s;
  endfunction

  function automatic step_t rom_step(logic [PAT_W-1:0] pat, logic [STEP_W-1:0] idx);
    step_t s;
    s = '0;
    unique case (pat)
      3'd0: begin
        unique case (idx)
          5'd0:    s = mk_step(0, 0, 500, 1, 0, 500 / FADE_UNIT_MS);
          5'd1:    s = mk_step(30, 30, 1000, 1, 0, 1000 / FADE_UNIT_MS);
          5'd2:    s = mk_step(60, 60, 1500, 0, 0, 0);
          5'd3:    s = mk_step(40, 40, 1000, 0, 1, 0);
          5'd4:    s = mk_step(20, 20, 1500, 0, 0, 0);
          5'd5:    s = mk_step(5, 5, 1000, 0, 1, 0);
          5'd6:    s = mk_step(0, 0, 500, 0, 0, 0);
          5'd7:    s = mk_step(0, 0, 1000, 0, 0, 0);
          default: s = '0;
        endcase
      end
      3'd1: begin
        unique case (idx)
          5'd0:    s = mk_step(25, 0, 800, 1, 0, 800 / FADE_UNIT_MS);
          5'd1:    s = mk_step(0, 0, 200, 0, 0, 0);
          5'd2:    s = mk_step(0, 25, 800, 1, 0, 800 / FADE_UNIT_MS);
          5'd3:    s = mk_step(0, 0, 200, 0, 0, 0);
          5'd4:    s = mk_step(40, 0, 600, 1, 0, 600 / FADE_UNIT_MS);
          5'd5:    s = mk_step(0, 0, 200, 0, 0, 0);
          5'd6:    s = mk_step(0, 40, 600, 1, 0, 600 / FADE_UNIT_MS);
          5'd7:    s = mk_step(0, 0, 300, 0, 0, 0);
          5'd8:    s = mk_step(15, 15, 1200, 1, 1, 1200 / FADE_UNIT_MS);
          5'd9:    s = mk_step(0, 0, 800, 0, 0, 0);
          default: s = '0;
        endcase
      end
      3'd2: begin
        unique case (idx)
          5'd0:    s = mk_step(80, 80, 150, 0, 0, 0);
          5'd1:    s = mk_step(0, 0, 100, 0, 0, 0);
          5'd2:    s = mk_step(90, 90, 150, 0, 0, 0);
          5'd3:    s = mk_step(0, 0, 200, 0, 0, 0);
          5'd4:    s = mk_step(50, 50, 2000, 1, 0, 2000 / FADE_UNIT_MS);
          5'd5:    s = mk_step(10, 10, 2400, 0, 1, 0);
          default: s = '0;
        endcase
      end
      3'd3: begin
        unique case (idx)
          5'd0:    s = mk_step(30, 0, 300, 1, 0, 300 / FADE_UNIT_MS);
          5'd1:    s = mk_step(0, 30, 300, 1, 0, 300 / FADE_UNIT_MS);
          5'd2:    s = mk_step(45, 0, 400, 0, 0, 0);
          5'd3:    s = mk_step(0, 45, 400, 0, 0, 0);
          5'd4:    s = mk_step(60, 0, 500, 0, 0, 0);
          5'd5:    s = mk_step(0, 60, 500, 0, 0, 0);
          5'd6:    s = mk_step(75, 75, 1000, 0, 1, 0);
          5'd7:    s = mk_step(0, 0, 1600, 0, 0, 0);
          default: s = '0;
        endcase
      end
      3'd4: begin
        unique case (idx)
          5'd0:    s = mk_step(0, 0, 1000, 0, 0, 0);
          5'd1:    s = mk_step(40, 40, 4000, 1, 0, 4000 / FADE_UNIT_MS);
          5'd2:    s = mk_step(20, 20, 7000, 0, 0, 0);
          5'd3:    s = mk_step(10, 10, 8000, 0, 1, 0);
          default: s = '0;
        endcase
      end
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [STEP_W-1:0] pat_len(logic [PAT_W-1:0] pat);
    logic [STEP_W-1:0] n;
    unique case (pat)
      3'd0:    n = 5'd8;
      3'd1:    n = 5'd10;
      3'd2:    n = 5'd6;
      3'd3:    n = 5'd8;
      3'd4:    n = 5'd4;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [REP_W-1:0] pat_rep(logic [PAT_W-1:0] pat);
    logic [REP_W-1:0] n;
    unique case (pat)
      3'd0:    n = 4'd6;
      3'd1:    n = 4'd9;
      3'd2:    n = 4'd4;
      3'd3:    n = 4'd3;
      3'd4:    n = 4'd4;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [DUTY_W-1:0] clamp_max(logic [DUTY_W-1:0] v,
                                                  logic [DUTY_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

// ===== src/hps_item_if.sv =====
// Input channel carrying one command word
interface hps_item_if;
  import hps_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [PAT_W-1:0]  pattern_select;

  modport source (output valid, opcode, pattern_select, input ready);
  modport sink   (input valid, opcode, pattern_select, output ready);
endinterface

// ===== src/hps_result_if.sv =====
// Output channel carrying one status word
interface hps_result_if;
  import hps_pkg::*;

  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  left_duty;
  logic [DUTY_W-1:0]  right_duty;
  logic               left_on;
  logic               right_on;
  logic               playing;
  logic [STEP_W-1:0]  step_now;
  logic [REP_W-1:0]   repeat_now;
  logic               finished;
  logic [COUNT_W-1:0] start_count;

  modport source (output valid, left_duty, right_duty, left_on, right_on, playing,
                  step_now, repeat_now, finished, start_count, input ready);
  modport sink   (input valid, left_duty, right_duty, left_on, right_on, playing,
                  step_now, repeat_now, finished, start_count, output ready);
endinterface

// ===== src/hps_div.sv =====
// Iterative restoring divider for the fade step, one quotient bit per cycle
module hps_div
  import hps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DUTY_W-1:0] dividend,
  input  logic [FDIV_W-1:0] divisor,
  output logic [DUTY_W-1:0] quotient,
  output logic              done
);

  logic [DUTY_W-1:0]    quo;
  logic [FDIV_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [FDIV_W:0]      trial;
  logic [FDIV_W:0]      diff;
  logic                 fits;

  assign trial    = {rem, quo[DUTY_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign fits     = trial >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DUTY_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[FDIV_W-1:0] : trial[FDIV_W-1:0];
      quo <= {quo[DUTY_W-2:0], fits};
    end
  end

endmodule

// ===== src/hps_ctrl.sv =====
// Sequencing state machine for command decode, fade and step advance
module hps_ctrl
  import hps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  hps_stat_t stat,
  output hps_ctl_t  ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (stat.item_valid) state_next = S_DECODE;
      S_DECODE:  state_next = stat.tick_live ? S_PREP : S_PUBLISH;
      S_PREP:    state_next = stat.fade_any ? S_LSTART : S_ADVANCE;
      S_LSTART:  state_next = S_LWAIT;
      S_LWAIT:   if (stat.div_done) state_next = S_RSTART;
      S_RSTART:  state_next = S_RWAIT;
      S_RWAIT:   if (stat.div_done) state_next = S_ADVANCE;
      S_ADVANCE: state_next = S_PUBLISH;
      S_PUBLISH: if (stat.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.take       = (state == S_IDLE);
    ctl.decode     = (state == S_DECODE);
    ctl.prep       = (state == S_PREP);
    ctl.div_start  = (state == S_LSTART) || (state == S_RSTART);
    ctl.side_right = (state == S_RSTART) || (state == S_RWAIT);
    ctl.apply      = ((state == S_LWAIT) || (state == S_RWAIT)) && stat.div_done;
    ctl.advance    = (state == S_ADVANCE);
    ctl.publish    = (state == S_PUBLISH) && stat.out_free;
  end

endmodule

// ===== src/hps_dp.sv =====
// Pattern state, fade arithmetic and output register
module hps_dp
  import hps_pkg::*;
#(
  parameter int STEPS = STEPS_PER_PATTERN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [DUTY_W-1:0] cfg_data,
  hps_item_if.sink          item,
  hps_result_if.source      result,
  input  hps_ctl_t          ctl,
  output hps_stat_t         stat
);

  logic [DUTY_W-1:0]  duty_limit;
  logic [OP_W-1:0]    op_q;
  logic [PAT_W-1:0]   sel_q;
  logic [PAT_W-1:0]   pattern_id;
  logic [STEP_W-1:0]  step_index;
  logic [MS_W-1:0]    step_elapsed;
  logic [REP_W-1:0]   repeat_index;
  logic               active;
  logic [FDIV_W-1:0]  fade_divisor;
  logic [DUTY_W-1:0]  tgt_left;
  logic [DUTY_W-1:0]  tgt_right;
  logic [DUTY_W-1:0]  duty_left;
  logic [DUTY_W-1:0]  duty_right;
  logic [COUNT_W-1:0] started_total;
  logic               fin_flag;

  step_t              cur_step;
  logic [MS_W-1:0]    half;
  logic               fade_in;
  logic               fade_dn;
  logic [DUTY_W-1:0]  cur;
  logic [DUTY_W-1:0]  goal;
  logic               up;
  logic [DUTY_W-1:0]  mag;
  logic [DUTY_W-1:0]  quo;
  logic [DUTY_W-1:0]  q_adj;
  logic [DUTY_W-1:0]  faded;
  logic [DUTY_W-1:0]  fade_result;
  logic               div_done;
  logic               do_start;
  logic [MS_W-1:0]    elapsed_sum;
  logic [STEP_W-1:0]  step_inc;
  logic [REP_W-1:0]   repeat_inc;

  assign cur_step = (int'(step_index) < STEPS) ? rom_step(pattern_id, step_index) : '0;
  assign half     = cur_step.dur >> 1;
  assign fade_in  = cur_step.fin && (step_elapsed < half);
  assign fade_dn  = cur_step.fout && (step_elapsed > half);

  assign cur   = ctl.side_right ? duty_right : duty_left;
  assign goal  = fade_in ? (ctl.side_right ? tgt_right : tgt_left) : '0;
  assign up    = goal > cur;
  assign mag   = up ? goal - cur : cur - goal;
  assign q_adj = ((quo == '0) && (mag != '0)) ? DUTY_W'(1) : quo;
  assign faded = up ? cur + q_adj : cur - q_adj;
  assign fade_result = (fade_divisor == '0) ? clamp_max(goal, duty_limit)
                                            : clamp_max(faded, duty_limit);

  assign do_start = (op_q == OP_START) || ((op_q == OP_START_IDLE) && !active);
  assign elapsed_sum = step_elapsed + MS_W'(TICK_MS);
  assign step_inc    = step_index + 1'b1;
  assign repeat_inc  = repeat_index + 1'b1;

  hps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (mag),
    .divisor  (fade_divisor),
    .quotient (quo),
    .done     (div_done)
  );

  assign item.ready = ctl.take;

  assign stat.item_valid = item.valid;
  assign stat.tick_live  = (op_q == OP_TICK) && active;
  assign stat.fade_any   = fade_in || fade_dn;
  assign stat.div_done   = div_done;
  assign stat.out_free   = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (item.valid && ctl.take) begin
      op_q  <= item.opcode;
      sel_q <= item.pattern_select;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_limit    <= DUTY_LIMIT_RESET;
      pattern_id    <= '0;
      step_index    <= '0;
      step_elapsed  <= '0;
      repeat_index  <= '0;
      active        <= 1'b0;
      fade_divisor  <= '0;
      tgt_left      <= '0;
      tgt_right     <= '0;
      duty_left     <= '0;
      duty_right    <= '0;
      started_total <= '0;
      fin_flag      <= 1'b0;
    end else begin
      if (cfg_we) begin
        duty_limit <= cfg_data;
      end
      if (ctl.decode) begin
        fin_flag <= 1'b0;
        if ((op_q == OP_START) && active) begin
          duty_left  <= '0;
          duty_right <= '0;
        end
        if (do_start) begin
          pattern_id    <= sel_q[PAT_W-1] ? BREATH_ID : sel_q;
          step_index    <= '0;
          step_elapsed  <= '0;
          repeat_index  <= '0;
          active        <= 1'b1;
          started_total <= started_total + 1'b1;
        end
      end
      if (ctl.prep && (step_elapsed == '0)) begin
        tgt_left  <= cur_step.left;
        tgt_right <= cur_step.right;
        if (cur_step.fin) begin
          fade_divisor <= cur_step.fdiv;
          duty_left    <= '0;
          duty_right   <= '0;
        end else begin
          duty_left    <= clamp_max(cur_step.left, duty_limit);
          duty_right   <= clamp_max(cur_step.right, duty_limit);
        end
      end
      if (ctl.apply) begin
        if (ctl.side_right) begin
          duty_right <= fade_result;
        end else begin
          duty_left  <= fade_result;
        end
      end
      if (ctl.advance) begin
        if (elapsed_sum >= cur_step.dur) begin
          step_elapsed <= '0;
          step_index   <= step_inc;
          if (step_inc >= pat_len(pattern_id)) begin
            repeat_index <= repeat_inc;
            if (repeat_inc >= pat_rep(pattern_id)) begin
              active     <= 1'b0;
              duty_left  <= '0;
              duty_right <= '0;
              fin_flag   <= 1'b1;
            end else begin
              step_index <= '0;
            end
          end
        end else begin
          step_elapsed <= elapsed_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ctl.publish) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      result.left_duty   <= duty_left;
      result.right_duty  <= duty_right;
      result.left_on     <= duty_left != '0;
      result.right_on    <= duty_right != '0;
      result.playing     <= active;
      result.step_now    <= step_index;
      result.repeat_now  <= repeat_index;
      result.finished    <= fin_flag;
      result.start_count <= started_total;
    end
  end

endmodule

// ===== src/haptic_pattern_sequencer.sv =====
// Two-motor haptic pattern sequencer: one status word per command word.
// Starts, idle ticks and unused opcodes go from decode straight to publish; ticks
// without fade pass prep and advance; ticks with fade also run the 7-bit divider
// for the left and then the right motor. One command word is in work at a time;
// the next can be taken in the cycle after the result loads.
// Synchronous reset clears pattern state, duties, counters; duty limit to 100.
module haptic_pattern_sequencer
  import hps_pkg::*;
#(
  parameter int STEPS = STEPS_PER_PATTERN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [DUTY_W-1:0] cfg_data,
  hps_item_if.sink          item,
  hps_result_if.source      result
);

  hps_ctl_t  ctl;
  hps_stat_t stat;

  hps_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  hps_dp #(
    .STEPS (STEPS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item),
    .result   (result),
    .ctl      (ctl),
    .stat     (stat)
  );

  a_take_one: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("second command word taken while one is in work");

  a_done_ends_play: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.finished |-> !result.playing && (result.left_duty == '0)
      && (result.right_duty == '0))
    else $error("finished word shows a live pattern or nonzero duty");

  a_on_flags: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.left_on == (result.left_duty != '0))
      && (result.right_on == (result.right_duty != '0)))
    else $error("motor enable disagrees with duty");

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    ctl.publish |-> !result.valid || result.ready)
    else $error("result word overwritten before it was taken");

endmodule
